### sv/lmrs_pkg.sv
// Package for the LED matrix row scan controller.
// Holds the command and status beat types, opcodes and default sizes.
// No dependencies.
package lmrs_pkg;

  localparam int COLUMNS_DEF = 32;
  localparam int ROWS_DEF    = 8;
  localparam int WORD_W      = 8;

  localparam logic [2:0] OP_SET_PIXEL   = 3'd0;
  localparam logic [2:0] OP_CLEAR_ALL   = 3'd1;
  localparam logic [2:0] OP_ALL_ON      = 3'd2;
  localparam logic [2:0] OP_CLEAR_ZONE  = 3'd3;
  localparam logic [2:0] OP_ROW_TICK    = 3'd4;
  localparam logic [2:0] OP_CLOCK_RISE  = 3'd5;
  localparam logic [2:0] OP_CLOCK_FALL  = 3'd6;

  typedef struct packed {
    logic [2:0] opcode;
    logic [4:0] column;
    logic [2:0] row;
    logic       pixel_on;
    logic [4:0] zone_first;
    logic [7:0] zone_last;
  } cmd_t;

  typedef struct packed {
    logic       serial_data;
    logic       serial_clock;
    logic       latch_strobe;
    logic [2:0] row_address;
    logic       shifting;
    logic       tick_skipped;
  } status_t;

endpackage

### sv/led_matrix_row_scan_controller_core.sv
// Top level of the LED matrix row scan controller.
// Frame store in a synchronous RAM plus the scan and shift sequencer.
// Depends on lmrs_pkg.

// The block drives a multiplexed LED matrix of COLUMNS columns by ROWS rows. Each
// command beat yields exactly one status beat. After reset the frame RAM is cleared
// by a pass over every column, during which cmd_stall is high. The frame RAM has one
// port pair and a registered read. A pixel write is a read, modify, write of its
// column word; clear all and all on write every column, a zone clear each column
// from its first to its clipped last; a row tick that starts a scan reads every
// column word once to build the shift pattern. A new command may be taken while
// the previous status beat is still held.
module led_matrix_row_scan_controller_core
  import lmrs_pkg::*;
#(
  parameter int COLUMNS = COLUMNS_DEF,
  parameter int ROWS    = ROWS_DEF
) (
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  output logic    cmd_stall,
  input  cmd_t    cmd,
  output logic    status_valid,
  input  logic    status_stall,
  output status_t status
);

  localparam int CW  = $clog2(COLUMNS);
  localparam int BLW = $clog2(COLUMNS + 1);
  localparam logic [CW-1:0]  LAST_IDX  = CW'(COLUMNS - 1);
  localparam logic [7:0]     LAST_COL8 = 8'(COLUMNS - 1);
  localparam logic [BLW-1:0] FULL_CNT  = BLW'(COLUMNS);
  localparam logic [2:0]     LAST_ROW  = 3'(ROWS - 1);

  localparam logic [2:0] ST_IDLE     = 3'd0;
  localparam logic [2:0] ST_INIT     = 3'd1;
  localparam logic [2:0] ST_FILL     = 3'd2;
  localparam logic [2:0] ST_PIX_RD   = 3'd3;
  localparam logic [2:0] ST_PIX_WR   = 3'd4;
  localparam logic [2:0] ST_SCAN     = 3'd5;
  localparam logic [2:0] ST_SCAN_END = 3'd6;
  localparam logic [2:0] ST_FINISH   = 3'd7;

  logic [WORD_W-1:0] frame [COLUMNS];
  logic [WORD_W-1:0] rd_data;
  logic              mem_we;
  logic [WORD_W-1:0] mem_wdata;

  logic [2:0]         state;
  logic [CW-1:0]      idx;
  logic [CW-1:0]      hi_idx;
  logic [WORD_W-1:0]  fill_val;
  logic [2:0]         pix_row;
  logic               pix_on;
  logic               rd_pend;

  logic [COLUMNS-1:0] shift_bits;
  logic [BLW-1:0]     bits_left;
  logic [BLW-1:0]     bits_left_m1;
  logic [2:0]         current_row;
  logic [2:0]         driven_row;
  logic               shift_active;
  logic               clock_level;
  logic               data_level;
  logic               strobe;
  logic               skipped;

  logic               accept;
  logic               out_free;
  logic [7:0]         zone_end;
  logic [7:0]         zone_start;

  assign cmd_stall    = (state != ST_IDLE);
  assign accept       = cmd_valid && !cmd_stall;
  assign out_free     = !status_valid || !status_stall;
  assign bits_left_m1 = bits_left - BLW'(1);
  assign zone_end     = (cmd.zone_last > LAST_COL8) ? LAST_COL8 : cmd.zone_last;
  assign zone_start   = {3'b000, cmd.zone_first};

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = fill_val;
    if (state == ST_FILL || state == ST_INIT) begin
      mem_we = 1'b1;
    end else if (state == ST_PIX_WR) begin
      mem_we    = 1'b1;
      mem_wdata = (rd_data & ~(8'h01 << pix_row)) | (8'(pix_on) << pix_row);
    end
  end

  // Frame RAM: one write and one registered read per cycle, both at idx.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      frame[idx] <= mem_wdata;
    end
    rd_data <= frame[idx];
  end

  // Column words come from the registered read; shifting them in from the top
  // leaves column 0 in bit 0 once every column has been seen.
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_bits <= COLUMNS'(1);
    end else if (rd_pend) begin
      shift_bits <= {~rd_data[current_row], shift_bits[COLUMNS-1:1]};
    end else if (accept && cmd.opcode == OP_CLOCK_FALL && shift_active &&
                 bits_left != '0) begin
      shift_bits <= shift_bits;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      idx          <= '0;
      hi_idx       <= LAST_IDX;
      fill_val     <= '0;
      rd_pend      <= 1'b0;
      bits_left    <= '0;
      current_row  <= '0;
      driven_row   <= '0;
      shift_active <= 1'b0;
      clock_level  <= 1'b0;
      data_level   <= 1'b0;
      strobe       <= 1'b0;
      skipped      <= 1'b0;
      status_valid <= 1'b0;
    end else begin
      rd_pend <= (state == ST_SCAN);
      if (status_valid && !status_stall) begin
        status_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            strobe  <= 1'b0;
            skipped <= 1'b0;
            state   <= ST_FINISH;
            unique case (cmd.opcode)
              OP_SET_PIXEL: begin
                if (int'(cmd.column) < COLUMNS) begin
                  idx     <= CW'(cmd.column);
                  pix_row <= cmd.row;
                  pix_on  <= cmd.pixel_on;
                  state   <= ST_PIX_RD;
                end
              end
              OP_CLEAR_ALL, OP_ALL_ON: begin
                idx      <= '0;
                hi_idx   <= LAST_IDX;
                fill_val <= (cmd.opcode == OP_ALL_ON) ? 8'hFF : 8'h00;
                state    <= ST_FILL;
              end
              OP_CLEAR_ZONE: begin
                if (zone_start <= zone_end) begin
                  idx      <= CW'(cmd.zone_first);
                  hi_idx   <= CW'(zone_end);
                  fill_val <= 8'h00;
                  state    <= ST_FILL;
                end
              end
              OP_ROW_TICK: begin
                if (shift_active) begin
                  skipped <= 1'b1;
                end else begin
                  strobe       <= 1'b1;
                  driven_row   <= current_row;
                  current_row  <= (current_row == LAST_ROW) ? 3'd0 : current_row + 3'd1;
                  bits_left    <= FULL_CNT;
                  shift_active <= 1'b1;
                  idx          <= '0;
                  state        <= ST_SCAN;
                end
              end
              OP_CLOCK_RISE: begin
                if (shift_active) begin
                  clock_level <= 1'b1;
                  if (bits_left == '0) begin
                    shift_active <= 1'b0;
                  end
                end
              end
              OP_CLOCK_FALL: begin
                if (shift_active) begin
                  clock_level <= 1'b0;
                  if (bits_left != '0) begin
                    bits_left  <= bits_left_m1;
                    data_level <= shift_bits[bits_left_m1[CW-1:0]];
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        ST_INIT: begin
          idx <= idx + CW'(1);
          if (idx == LAST_IDX) begin
            state <= ST_IDLE;
          end
        end
        ST_FILL: begin
          idx <= idx + CW'(1);
          if (idx == hi_idx) begin
            state <= ST_FINISH;
          end
        end
        ST_PIX_RD: begin
          state <= ST_PIX_WR;
        end
        ST_PIX_WR: begin
          state <= ST_FINISH;
        end
        ST_SCAN: begin
          idx <= idx + CW'(1);
          if (idx == LAST_IDX) begin
            state <= ST_SCAN_END;
          end
        end
        ST_SCAN_END: begin
          state <= ST_FINISH;
        end
        ST_FINISH: begin
          if (out_free) begin
            status_valid <= 1'b1;
            state        <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Status payload is loaded only when a beat is issued, so a stalled beat holds.
  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      status.serial_data  <= data_level;
      status.serial_clock <= clock_level;
      status.latch_strobe <= strobe;
      status.row_address  <= driven_row;
      status.shifting     <= shift_active;
      status.tick_skipped <= skipped;
    end
  end

endmodule

### tb/lmrs_scan_monitor.sv
`timescale 1ns / 1ps
// Watches the command and status channels of the LED matrix row scan controller.
// It predicts each status beat, queues it and compares it with the beat that arrives.
// Depends on lmrs_pkg.
module lmrs_scan_monitor
  import lmrs_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    cmd_valid,
  input  logic    cmd_stall,
  input  cmd_t    cmd,
  input  logic    status_valid,
  input  logic    status_stall,
  input  status_t status,
  output int      mismatches,
  output int      waiting
);

  // The frame is kept as one column word per column, with bit r holding row r.
  logic [WORD_W-1:0]      frame [COLUMNS_DEF];
  logic [COLUMNS_DEF-1:0] row_pattern;
  int unsigned            bits_to_go;
  logic [2:0]             next_row;
  logic [2:0]             shown_row;
  logic                   scanning;
  logic                   clock_line;
  logic                   data_line;
  status_t                expected_status [$];
  int                     beat_no;

  initial begin
    mismatches = 0;
    waiting    = 0;
    beat_no    = 0;
  end

  task automatic report_mismatch(input string what, input int got_v, input int want_v);
    $display("[%0t] status beat %0d: %s, got %0d, expected %0d",
             $time, beat_no, what, got_v, want_v);
    mismatches++;
  endtask

  task automatic scan_step(input cmd_t c, output status_t s);
    int   i;
    int   last;
    logic strobe;
    logic skipped;
    strobe  = 1'b0;
    skipped = 1'b0;
    case (c.opcode)
      OP_SET_PIXEL: begin
        frame[c.column][c.row] = c.pixel_on;
      end
      OP_CLEAR_ALL: begin
        for (i = 0; i < COLUMNS_DEF; i++) frame[i] = '0;
      end
      OP_ALL_ON: begin
        for (i = 0; i < COLUMNS_DEF; i++) frame[i] = '1;
      end
      OP_CLEAR_ZONE: begin
        last = (c.zone_last > COLUMNS_DEF - 1) ? COLUMNS_DEF - 1 : int'(c.zone_last);
        for (i = int'(c.zone_first); i <= last; i++) frame[i] = '0;
      end
      OP_ROW_TICK: begin
        if (scanning) begin
          skipped = 1'b1;
        end else begin
          strobe    = 1'b1;
          shown_row = next_row;
          next_row  = 3'((next_row + 1) % ROWS_DEF);
          // The pattern is taken from the row that follows the one now driven,
          // inverted because the column drivers sink current.
          for (i = 0; i < COLUMNS_DEF; i++) row_pattern[i] = ~frame[i][next_row];
          bits_to_go = COLUMNS_DEF;
          scanning   = 1'b1;
        end
      end
      OP_CLOCK_RISE: begin
        if (scanning) begin
          clock_line = 1'b1;
          if (bits_to_go == 0) scanning = 1'b0;
        end
      end
      OP_CLOCK_FALL: begin
        if (scanning) begin
          clock_line = 1'b0;
          if (bits_to_go != 0) begin
            bits_to_go--;
            data_line = row_pattern[bits_to_go];
          end
        end
      end
      default: begin
      end
    endcase
    s.serial_data  = data_line;
    s.serial_clock = clock_line;
    s.latch_strobe = strobe;
    s.row_address  = shown_row;
    s.shifting     = scanning;
    s.tick_skipped = skipped;
  endtask

  always @(posedge clk) begin : track
    status_t fresh;
    status_t want;
    int      i;
    if (rst) begin
      for (i = 0; i < COLUMNS_DEF; i++) frame[i] = '0;
      row_pattern = COLUMNS_DEF'(1);
      bits_to_go  = 0;
      next_row    = '0;
      shown_row   = '0;
      scanning    = 1'b0;
      clock_line  = 1'b0;
      data_line   = 1'b0;
      expected_status.delete();
    end else begin
      if (cmd_valid && !cmd_stall) begin
        scan_step(cmd, fresh);
        expected_status.push_back(fresh);
      end
      if (status_valid && !status_stall) begin
        if (expected_status.size() == 0) begin
          report_mismatch("beat with no command outstanding", 1, 0);
        end else begin
          want = expected_status.pop_front();
          if (status.serial_data !== want.serial_data)
            report_mismatch("serial_data", int'(status.serial_data),
                            int'(want.serial_data));
          if (status.serial_clock !== want.serial_clock)
            report_mismatch("serial_clock", int'(status.serial_clock),
                            int'(want.serial_clock));
          if (status.latch_strobe !== want.latch_strobe)
            report_mismatch("latch_strobe", int'(status.latch_strobe),
                            int'(want.latch_strobe));
          if (status.row_address !== want.row_address)
            report_mismatch("row_address", int'(status.row_address),
                            int'(want.row_address));
          if (status.shifting !== want.shifting)
            report_mismatch("shifting", int'(status.shifting), int'(want.shifting));
          if (status.tick_skipped !== want.tick_skipped)
            report_mismatch("tick_skipped", int'(status.tick_skipped),
                            int'(want.tick_skipped));
        end
        beat_no++;
      end
    end
    waiting = expected_status.size();
  end

endmodule

### tb/led_matrix_row_scan_controller_core_test.sv
`timescale 1ns / 1ps
// Top of the testbench for the LED matrix row scan controller: clock, reset and stimulus.
// Checking is done by lmrs_scan_monitor; depends on lmrs_pkg and the core.
module led_matrix_row_scan_controller_core_test;
  import lmrs_pkg::*;

  localparam logic [2:0] OP_UNUSED     = 3'd7;
  localparam int         ITEM_TARGET   = 1100;
  localparam int         HOLD_CYCLES   = 400;
  localparam int         SETTLE_CYCLES = COLUMNS_DEF + 8;

  logic    clk          = 1'b0;
  logic    rst          = 1'b1;
  logic    cmd_valid    = 1'b0;
  logic    cmd_stall;
  cmd_t    cmd          = '0;
  logic    status_valid;
  logic    status_stall = 1'b0;
  status_t status;
  int      mismatches;
  int      waiting;
  int      sent         = 0;
  int      got          = 0;
  bit      calm         = 1'b0;
  bit      hold_req     = 1'b0;

  always #5 clk = ~clk;

  led_matrix_row_scan_controller_core uut (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .cmd          (cmd),
    .status_valid (status_valid),
    .status_stall (status_stall),
    .status       (status)
  );

  lmrs_scan_monitor scan_monitor (
    .clk          (clk),
    .rst          (rst),
    .cmd_valid    (cmd_valid),
    .cmd_stall    (cmd_stall),
    .cmd          (cmd),
    .status_valid (status_valid),
    .status_stall (status_stall),
    .status       (status),
    .mismatches   (mismatches),
    .waiting      (waiting)
  );

  initial begin
    #5_000_000;
    $display("FAIL led_matrix_row_scan_controller_core");
    $finish;
  end

  function automatic cmd_t any_cmd();
    cmd_t c;
    c.opcode     = 3'($urandom_range(0, 7));
    c.column     = 5'($urandom);
    c.row        = 3'($urandom);
    c.pixel_on   = 1'($urandom);
    c.zone_first = 5'($urandom);
    c.zone_last  = 8'($urandom);
    return c;
  endfunction

  function automatic cmd_t op_cmd(input logic [2:0] op);
    cmd_t c;
    c        = any_cmd();
    c.opcode = op;
    return c;
  endfunction

  function automatic cmd_t pix_cmd(input logic [4:0] col, input logic [2:0] r,
                                   input logic on);
    cmd_t c;
    c          = op_cmd(OP_SET_PIXEL);
    c.column   = col;
    c.row      = r;
    c.pixel_on = on;
    return c;
  endfunction

  function automatic cmd_t zone_cmd(input logic [4:0] first, input logic [7:0] last);
    cmd_t c;
    c            = op_cmd(OP_CLEAR_ZONE);
    c.zone_first = first;
    c.zone_last  = last;
    return c;
  endfunction

  // Offers one beat and returns once cmd_stall is low. Idle gaps come before the
  // beat, so valid is only ever lowered in a step that is followed by a wait.
  task automatic send_item(input cmd_t c);
    while (!calm && $urandom_range(0, 99) < 8) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd       <= c;
    @(posedge clk);
    while (cmd_stall) @(posedge clk);
    sent++;
  endtask

  task automatic drain();
    cmd_valid <= 1'b0;
    @(posedge clk);
    while (got != sent) @(posedge clk);
  endtask

  // Status side: random stalls, plus one long hold-off while commands keep coming.
  initial begin : status_sink
    int hold_left;
    bit held;
    hold_left = 0;
    held      = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && status_valid && !status_stall) got++;
      if (hold_req && !held) begin
        hold_left = HOLD_CYCLES;
        held      = 1'b1;
      end
      if (hold_left > 0) begin
        status_stall <= 1'b1;
        hold_left--;
      end else begin
        status_stall <= !calm && ($urandom_range(0, 99) < 8);
      end
    end
  end

  initial begin : stimulus
    int k;
    int n;
    int pick;
    bit paused;
    paused = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // Clock ticks and the spare opcode while nothing is being shifted.
    send_item(op_cmd(OP_CLOCK_RISE));
    send_item(op_cmd(OP_CLOCK_FALL));
    send_item(op_cmd(OP_UNUSED));
    send_item(pix_cmd(5'd0, 3'd0, 1'b1));
    send_item(pix_cmd(5'd31, 3'd7, 1'b1));
    send_item(pix_cmd(5'd17, 3'd1, 1'b1));
    send_item(pix_cmd(5'd17, 3'd1, 1'b0));
    send_item(pix_cmd(5'd30, 3'd1, 1'b1));
    send_item(op_cmd(OP_ROW_TICK));
    // A second tick mid-shift must only be flagged as skipped.
    send_item(op_cmd(OP_ROW_TICK));
    send_item(op_cmd(OP_CLOCK_FALL));
    send_item(op_cmd(OP_CLOCK_RISE));
    send_item(op_cmd(OP_CLOCK_FALL));
    send_item(op_cmd(OP_ALL_ON));
    send_item(zone_cmd(5'd0, 8'd255));
    send_item(op_cmd(OP_ALL_ON));
    send_item(zone_cmd(5'd31, 8'd31));
    send_item(zone_cmd(5'd20, 8'd5));
    send_item(zone_cmd(5'd4, 8'd40));
    send_item(op_cmd(OP_UNUSED));
    send_item(op_cmd(OP_CLEAR_ALL));
    send_item(pix_cmd(5'd31, 3'd0, 1'b1));
    send_item(op_cmd(OP_ROW_TICK));
    drain();

    while (sent < ITEM_TARGET) begin
      if (!paused && sent >= 300) begin
        drain();
        paused = 1'b1;
      end
      if (sent >= 500) hold_req = 1'b1;
      calm = (sent >= 700 && sent < 900);
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        // A full row: tick, one rise and fall per column, then the rise that ends it.
        send_item(op_cmd(OP_ROW_TICK));
        for (k = 0; k < COLUMNS_DEF; k++) begin
          send_item(op_cmd(OP_CLOCK_RISE));
          if ($urandom_range(0, 11) == 0) send_item(any_cmd());
          send_item(op_cmd(OP_CLOCK_FALL));
        end
        if ($urandom_range(0, 3) == 0) send_item(op_cmd(OP_CLOCK_FALL));
        send_item(op_cmd(OP_CLOCK_RISE));
      end else if (pick < 85) begin
        n = $urandom_range(1, 12);
        repeat (n) send_item(pix_cmd(5'($urandom), 3'($urandom), 1'($urandom)));
        case ($urandom_range(0, 5))
          0: send_item(op_cmd(OP_CLEAR_ALL));
          1: send_item(op_cmd(OP_ALL_ON));
          2, 3: begin
            if ($urandom_range(0, 1) == 1)
              send_item(zone_cmd(5'($urandom), 8'($urandom_range(0, 31))));
            else
              send_item(zone_cmd(5'($urandom), 8'($urandom_range(0, 255))));
          end
          default: begin
          end
        endcase
      end else begin
        n = $urandom_range(1, 4);
        repeat (n) send_item(any_cmd());
      end
    end
    calm = 1'b0;

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && waiting == 0)
      $display("PASS led_matrix_row_scan_controller_core");
    else
      $display("FAIL led_matrix_row_scan_controller_core");
    $finish;
  end

endmodule
